// File: src/rdiv_pkg.sv
`timescale 1ns / 1ps

package rdiv_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int SEED_W = 11;

   // Seed table: entry i is SEED_NUMERATOR / (i + SEED_BASE)
   localparam int unsigned SEED_NUMERATOR = 32'h0007_FD00;
   localparam int unsigned SEED_BASE      = 256;
   localparam int          SEED_ENTRIES   = 256;

   localparam logic [WORD_W-1:0] NEWTON_ONE = 64'h1000_0000_0000_0000;

   // Register stages from request to response
   localparam int PIPE_DEPTH  = 24;
   // Stage whose register first holds the reciprocal
   localparam int RECIP_STAGE = 15;

   typedef struct packed {
      logic [WORD_W-1:0] dividend_high;
      logic [WORD_W-1:0] dividend_low;
      logic [WORD_W-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] quotient;
      logic [WORD_W-1:0] remainder_out;
      logic [WORD_W-1:0] reciprocal;
      logic              bad_operand;
   } rsp_type;

   // Operands and flags that ride along the pipeline
   typedef struct packed {
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] d;
      logic              bad;
      logic [WORD_W-1:0] recip;
   } ctx_type;

endpackage

// File: src/reciprocal_divide_128_by_64.sv
`timescale 1ns / 1ps

// 128-by-64 unsigned divider built on a multiply-only reciprocal.
//
// Request: req_payload carries dividend_high, dividend_low and divisor. A transfer
// happens at a rising edge with start high and busy low. busy is always low: the
// pipeline takes a new request every cycle.
// Response: rsp_payload carries quotient, remainder_out, reciprocal and
// bad_operand, valid for the single cycle in which rsp_valid is high. The
// receiver cannot hold it off, and none is needed: nothing ever waits.
// The response for a request passes through every register stage, valid_ff[0]
// to valid_ff[PIPE_DEPTH-1], and is shown while rsp_valid is high.
// Throughput: one division per cycle. Latency is set by the chain of
// multiplier stages: seed refinement (two Newton steps, a third step and a
// correction) followed by the quotient multiply and its two fix-ups, each
// product registered before it is summed.
// bad_operand is set when divisor bit 63 is clear (then quotient, remainder and
// reciprocal are zero) or when dividend_high >= divisor (then quotient and
// remainder are zero, reciprocal is still valid).
// Reset: synchronous, clears all valid bits; requests in flight are dropped and
// no response appears until new requests arrive.
module reciprocal_divide_128_by_64 (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rdiv_pkg::req_type req_payload,
   output logic              rsp_valid,
   output rdiv_pkg::rsp_type rsp_payload
);

   localparam int DEPTH = rdiv_pkg::PIPE_DEPTH;
   localparam int RSTG  = rdiv_pkg::RECIP_STAGE;

   // ---------------------------------------------------------------
   // Seed ROM, built at elaboration
   // ---------------------------------------------------------------
   logic [rdiv_pkg::SEED_W-1:0] seed_tab [rdiv_pkg::SEED_ENTRIES];

   for (genvar i = 0; i < rdiv_pkg::SEED_ENTRIES; i++) begin : g_seed
      localparam int unsigned SEED_VAL =
         rdiv_pkg::SEED_NUMERATOR / (i + rdiv_pkg::SEED_BASE);
      assign seed_tab[i] = rdiv_pkg::SEED_W'(SEED_VAL);
   end

   // ---------------------------------------------------------------
   // Control and context pipeline
   // ---------------------------------------------------------------
   logic                valid_ff [DEPTH];
   rdiv_pkg::ctx_type   ctx_ff   [DEPTH];
   rdiv_pkg::ctx_type   ctx_in   [DEPTH];
   logic                take_req;

   // reciprocal stage registers
   logic [10:0]  s0_in,    s0_k0_ff,    s0_k1_ff;
   logic [40:0]  top40_in, top40_k0_ff, top40_k1_ff, top40_k2_ff;
   logic [21:0]  s0sq_in,  s0sq_k0_ff;
   logic [62:0]  t_in,     t_k1_ff;
   logic [63:0]  s1_wide;
   logic [21:0]  s1_in,    s1_k2_ff,    s1_k3_ff,    s1_k4_ff,    s1_k5_ff;
   logic [62:0]  u_in,     u_k3_ff;
   logic [63:0]  e_in,     e_k4_ff;
   logic [53:0]  m0_in,    m0_k5_ff;
   logic [53:0]  m1_full;
   logic [31:0]  m1_in,    m1_k5_ff;
   logic [63:0]  m_sum;
   logic [35:0]  s2_in,    s2_k6_ff,    s2_k7_ff,    s2_k8_ff,    s2_k9_ff,    s2_k10_ff;
   logic [63:0]  half_in,  half_k6_ff;
   logic [67:0]  a0_full,  a1_full;
   logic [63:0]  a0_in,    a0_k7_ff;
   logic [31:0]  a1_in,    a1_k7_ff;
   logic [63:0]  err_mask;
   logic [63:0]  err_in,   err_k8_ff;
   logic [67:0]  b0_in,    b0_k9_ff,    b1_in,       b1_k9_ff;
   logic [99:0]  b_sum;
   logic [35:0]  ph_in,    ph_k10_ff;
   logic [63:0]  s3_in,    s3_k11_ff,   s3_k12_ff,   s3_k13_ff,   s3_k14_ff;
   logic [63:0]  rp00_in,  rp01_in,     rp10_in,     rp11_in;
   logic [63:0]  rp00_ff,  rp01_ff,     rp10_ff,     rp11_ff;
   logic [127:0] rx_in,    rx_ff;
   logic [64:0]  ry_in,    ry_ff;
   logic [127:0] r_full;
   logic [63:0]  hi2_in,   hi2_ff;
   logic [63:0]  recip_in;

   // quotient stage registers
   logic [63:0]  qp00_in,  qp01_in,     qp10_in,     qp11_in;
   logic [63:0]  qp00_ff,  qp01_ff,     qp10_ff,     qp11_ff;
   logic [127:0] qx_in,    qx_ff;
   logic [64:0]  qy_in,    qy_ff;
   logic [127:0] q_full;
   logic [63:0]  sum_hi_in, sum_hi_k18_ff;
   logic [63:0]  sum_lo_in, sum_lo_k18_ff, sum_lo_k19_ff, sum_lo_k20_ff, sum_lo_k21_ff;
   logic [63:0]  q1_in,    q1_k19_ff,   q1_k20_ff,   q_k21_ff;
   logic [63:0]  c0_in,    c0_ff;
   logic [63:0]  c1_full,  c2_full;
   logic [31:0]  c1_in,    c1_ff,       c2_in,       c2_ff;
   logic [31:0]  c_mid;
   logic [63:0]  r_in,     r_k21_ff;
   logic [63:0]  q_fix1_in, r_fix1_in,  q_k22_ff,    r_k22_ff;
   logic [63:0]  quo_in,   rem_in,      quo_k23_ff,  rem_k23_ff;

   assign busy     = 1'b0;
   assign take_req = start && !busy;

   // ---------------------------------------------------------------
   // Datapath, all stages in one combinational block
   // ---------------------------------------------------------------
   always_comb begin
      // k0: seed lookup, d40 + 1, seed squared, operand check
      s0_in    = seed_tab[req_payload.divisor[62:55]];
      top40_in = {1'b0, req_payload.divisor[63:24]} + 41'd1;
      s0sq_in  = {11'b0, s0_in} * {11'b0, s0_in};

      // k1: seed^2 * d40
      t_in = {41'b0, s0sq_k0_ff} * {22'b0, top40_k0_ff};

      // k2: first Newton step
      s1_wide = ({53'b0, s0_k1_ff} << 11) - {41'b0, t_k1_ff[62:40]} - 64'd1;
      s1_in   = s1_wide[21:0];

      // k3..k6: second Newton step
      u_in    = {41'b0, s1_k2_ff} * {22'b0, top40_k2_ff};
      e_in    = rdiv_pkg::NEWTON_ONE - {1'b0, u_k3_ff};
      m0_in   = {32'b0, s1_k4_ff} * {22'b0, e_k4_ff[31:0]};
      m1_full = {32'b0, s1_k4_ff} * {22'b0, e_k4_ff[63:32]};
      m1_in   = m1_full[31:0];
      m_sum   = {10'b0, m0_k5_ff} + {m1_k5_ff, 32'b0};
      s2_in   = {1'b0, s1_k5_ff, 13'b0} + {19'b0, m_sum[63:47]};
      half_in = {1'b0, ctx_ff[5].d[63:1]} + {63'b0, ctx_ff[5].d[0]};

      // k7..k11: third step
      a0_full  = {32'b0, s2_k6_ff} * {36'b0, half_k6_ff[31:0]};
      a1_full  = {32'b0, s2_k6_ff} * {36'b0, half_k6_ff[63:32]};
      a0_in    = a0_full[63:0];
      a1_in    = a1_full[31:0];
      err_mask = ctx_ff[7].d[0] ? {29'b0, s2_k7_ff[35:1]} : 64'd0;
      err_in   = err_mask - a0_k7_ff - {a1_k7_ff, 32'b0};
      b0_in    = {32'b0, s2_k8_ff} * {36'b0, err_k8_ff[31:0]};
      b1_in    = {32'b0, s2_k8_ff} * {36'b0, err_k8_ff[63:32]};
      b_sum    = {32'b0, b0_k9_ff} + {b1_k9_ff, 32'b0};
      ph_in    = b_sum[99:64];
      s3_in    = {29'b0, ph_k10_ff[35:1]} + {s2_k10_ff[32:0], 31'b0};

      // k12..k15: final correction, high word of s3*d + d
      rp00_in  = {32'b0, s3_k11_ff[31:0]}  * {32'b0, ctx_ff[11].d[31:0]};
      rp01_in  = {32'b0, s3_k11_ff[31:0]}  * {32'b0, ctx_ff[11].d[63:32]};
      rp10_in  = {32'b0, s3_k11_ff[63:32]} * {32'b0, ctx_ff[11].d[31:0]};
      rp11_in  = {32'b0, s3_k11_ff[63:32]} * {32'b0, ctx_ff[11].d[63:32]};
      rx_in    = {rp11_ff, rp00_ff} + {64'b0, ctx_ff[12].d};
      ry_in    = {1'b0, rp01_ff} + {1'b0, rp10_ff};
      r_full   = rx_ff + {31'b0, ry_ff, 32'b0};
      hi2_in   = r_full[127:64];
      recip_in = ctx_ff[14].d[63] ? (s3_k14_ff - hi2_ff - ctx_ff[14].d) : 64'd0;

      // k16..k18: reciprocal * high word + dividend
      qp00_in   = {32'b0, ctx_ff[RSTG].recip[31:0]}  * {32'b0, ctx_ff[RSTG].hi[31:0]};
      qp01_in   = {32'b0, ctx_ff[RSTG].recip[31:0]}  * {32'b0, ctx_ff[RSTG].hi[63:32]};
      qp10_in   = {32'b0, ctx_ff[RSTG].recip[63:32]} * {32'b0, ctx_ff[RSTG].hi[31:0]};
      qp11_in   = {32'b0, ctx_ff[RSTG].recip[63:32]} * {32'b0, ctx_ff[RSTG].hi[63:32]};
      qx_in     = {qp11_ff, qp00_ff} + {ctx_ff[16].hi, ctx_ff[16].lo};
      qy_in     = {1'b0, qp01_ff} + {1'b0, qp10_ff};
      q_full    = qx_ff + {31'b0, qy_ff, 32'b0};
      sum_hi_in = q_full[127:64];
      sum_lo_in = q_full[63:0];

      // k19..k21: trial quotient and remainder
      q1_in   = sum_hi_k18_ff + 64'd1;
      c0_in   = {32'b0, q1_k19_ff[31:0]} * {32'b0, ctx_ff[19].d[31:0]};
      c1_full = {32'b0, q1_k19_ff[31:0]} * {32'b0, ctx_ff[19].d[63:32]};
      c2_full = {32'b0, q1_k19_ff[63:32]} * {32'b0, ctx_ff[19].d[31:0]};
      c1_in   = c1_full[31:0];
      c2_in   = c2_full[31:0];
      c_mid   = c1_ff + c2_ff;
      r_in    = ctx_ff[20].lo - c0_ff - {c_mid, 32'b0};

      // k22: remainder wrapped past the low sum, step back
      if (r_k21_ff > sum_lo_k21_ff) begin
         q_fix1_in = q_k21_ff - 64'd1;
         r_fix1_in = r_k21_ff + ctx_ff[21].d;
      end else begin
         q_fix1_in = q_k21_ff;
         r_fix1_in = r_k21_ff;
      end

      // k23: remainder still at or above divisor, step forward; mask bad operands
      if (r_k22_ff >= ctx_ff[22].d) begin
         quo_in = q_k22_ff + 64'd1;
         rem_in = r_k22_ff - ctx_ff[22].d;
      end else begin
         quo_in = q_k22_ff;
         rem_in = r_k22_ff;
      end
      if (ctx_ff[22].bad) begin
         quo_in = 64'd0;
         rem_in = 64'd0;
      end
   end

   // context travels unchanged except for the reciprocal slot
   always_comb begin
      ctx_in[0].hi    = req_payload.dividend_high;
      ctx_in[0].lo    = req_payload.dividend_low;
      ctx_in[0].d     = req_payload.divisor;
      ctx_in[0].bad   = !req_payload.divisor[63] ||
                        (req_payload.dividend_high >= req_payload.divisor);
      ctx_in[0].recip = 64'd0;
      for (int k = 1; k < DEPTH; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end
      ctx_in[RSTG].recip = recip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= take_req;
         for (int k = 1; k < DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         ctx_ff[k] <= ctx_in[k];
      end
      s0_k0_ff      <= s0_in;
      top40_k0_ff   <= top40_in;
      s0sq_k0_ff    <= s0sq_in;
      t_k1_ff       <= t_in;
      s0_k1_ff      <= s0_k0_ff;
      top40_k1_ff   <= top40_k0_ff;
      s1_k2_ff      <= s1_in;
      top40_k2_ff   <= top40_k1_ff;
      u_k3_ff       <= u_in;
      s1_k3_ff      <= s1_k2_ff;
      e_k4_ff       <= e_in;
      s1_k4_ff      <= s1_k3_ff;
      m0_k5_ff      <= m0_in;
      m1_k5_ff      <= m1_in;
      s1_k5_ff      <= s1_k4_ff;
      s2_k6_ff      <= s2_in;
      half_k6_ff    <= half_in;
      a0_k7_ff      <= a0_in;
      a1_k7_ff      <= a1_in;
      s2_k7_ff      <= s2_k6_ff;
      err_k8_ff     <= err_in;
      s2_k8_ff      <= s2_k7_ff;
      b0_k9_ff      <= b0_in;
      b1_k9_ff      <= b1_in;
      s2_k9_ff      <= s2_k8_ff;
      ph_k10_ff     <= ph_in;
      s2_k10_ff     <= s2_k9_ff;
      s3_k11_ff     <= s3_in;
      rp00_ff       <= rp00_in;
      rp01_ff       <= rp01_in;
      rp10_ff       <= rp10_in;
      rp11_ff       <= rp11_in;
      s3_k12_ff     <= s3_k11_ff;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      s3_k13_ff     <= s3_k12_ff;
      hi2_ff        <= hi2_in;
      s3_k14_ff     <= s3_k13_ff;
      qp00_ff       <= qp00_in;
      qp01_ff       <= qp01_in;
      qp10_ff       <= qp10_in;
      qp11_ff       <= qp11_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      sum_hi_k18_ff <= sum_hi_in;
      sum_lo_k18_ff <= sum_lo_in;
      q1_k19_ff     <= q1_in;
      sum_lo_k19_ff <= sum_lo_k18_ff;
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      q1_k20_ff     <= q1_k19_ff;
      sum_lo_k20_ff <= sum_lo_k19_ff;
      r_k21_ff      <= r_in;
      q_k21_ff      <= q1_k20_ff;
      sum_lo_k21_ff <= sum_lo_k20_ff;
      q_k22_ff      <= q_fix1_in;
      r_k22_ff      <= r_fix1_in;
      quo_k23_ff    <= quo_in;
      rem_k23_ff    <= rem_in;
   end

   // ---------------------------------------------------------------
   // Response
   // ---------------------------------------------------------------
   assign rsp_valid                 = valid_ff[DEPTH-1];
   assign rsp_payload.quotient      = quo_k23_ff;
   assign rsp_payload.remainder_out = rem_k23_ff;
   assign rsp_payload.reciprocal    = ctx_ff[DEPTH-1].recip;
   assign rsp_payload.bad_operand   = ctx_ff[DEPTH-1].bad;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take_req, DEPTH))
      else $error("response without a matching request");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.bad_operand |->
         rsp_payload.remainder_out < ctx_ff[DEPTH-1].d)
      else $error("remainder not below divisor");

   a_bad_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_operand |->
         rsp_payload.quotient == 64'd0 && rsp_payload.remainder_out == 64'd0)
      else $error("bad operands must give zero quotient and remainder");

   a_unnorm_recip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ctx_ff[DEPTH-1].d[63] |->
         rsp_payload.reciprocal == 64'd0 && rsp_payload.bad_operand)
      else $error("unnormalized divisor must flag and zero the reciprocal");

endmodule
